// File: src/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg: shared types and constants of the biphase frame decoder
// Register indexes, window settings, beat payloads and the decoder state.
// ----------------------------------------------------------------------------
package bfd_pkg;

  // stored frame length, 8 to 64
  localparam int FRAME_WIDTH  = 32;
  localparam int RESULT_WIDTH = 32;
  // frame widened to at least the result width, so low bits can be picked
  localparam int WIDE_WIDTH   = (FRAME_WIDTH > RESULT_WIDTH) ? FRAME_WIDTH : RESULT_WIDTH;

  localparam int DUR_W       = 16;
  localparam int INDEX_W     = 8;
  localparam int COUNT_W     = INDEX_W - 1;
  localparam int CFG_INDEX_W = 3;

  localparam logic [DUR_W-1:0] MERGED_FILL_US = DUR_W'(417);
  localparam logic [COUNT_W-1:0] RESPONSE_BITS = COUNT_W'(8);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SHORT_LOW    = 3'd0,
    REG_SHORT_HIGH   = 3'd1,
    REG_LONG_LOW     = 3'd2,
    REG_LONG_HIGH    = 3'd3,
    REG_MERGED_LIMIT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [DUR_W-1:0] short_low;
    logic [DUR_W-1:0] short_high;
    logic [DUR_W-1:0] long_low;
    logic [DUR_W-1:0] long_high;
    logic [DUR_W-1:0] merged_start_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    short_low:          DUR_W'(333),
    short_high:         DUR_W'(500),
    long_low:           DUR_W'(667),
    long_high:          DUR_W'(1000),
    merged_start_limit: DUR_W'(650)
  };

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic             level;
    logic             first;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [RESULT_WIDTH-1:0] frame_bits;
    logic [COUNT_W-1:0]      bit_count;
    logic [7:0]              response_byte;
    logic                    response_valid;
  } result_t;

  typedef struct packed {
    logic [FRAME_WIDTH-1:0] frame;
    logic [INDEX_W-1:0]     half_index;
    logic                   previous_level;
  } dec_state_t;

  localparam dec_state_t DEC_CLEAR = '{
    frame:          '0,
    half_index:     '0,
    previous_level: 1'b1
  };

endpackage

// File: src/biphase_frame_decoder.sv
// ----------------------------------------------------------------------------
// biphase_frame_decoder: biphase receive decoder over measured half periods
// Decodes one captured frame from a run of half-period beats, one result
// beat per capture on its last half.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//  item      in         item_valid / item_ready   item (duration, level, first, last)
//  result    out        result_valid / result_ready  result (frame, count, response)
//
//  one item beat per cycle while the input is not stalled; a half is held in the
//  input register, and the decoder state and result register update as it leaves
//  a result is offered once its last half has left the input register
//  reset (rst, synchronous) restores window defaults and clears the decoder
//  a stalled result only holds back a following last half; other halves flow
//  cfg_ready is always high; writes to indexes beyond the list are dropped
// ----------------------------------------------------------------------------
module biphase_frame_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bfd_pkg::DUR_W-1:0]         cfg_data,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  bfd_pkg::item_t                    item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output bfd_pkg::result_t                  result
);
  import bfd_pkg::*;

  // window settings
  cfg_t cfg;

  // input register
  logic  in_valid_q;
  item_t in_q;

  // decoder state
  dec_state_t st;
  logic       stopped;
  logic       just_after_first;

  // next-state terms
  dec_state_t st_next;
  dec_state_t half_next;
  dec_state_t merged_next;
  logic       stopped_next;
  logic       just_after_first_next;
  logic       half_stop;
  logic       merged_stop;
  logic       adv;
  logic [WIDE_WIDTH-1:0] frame_wide;
  logic [COUNT_W-1:0]    count_next;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SHORT_LOW:    cfg.short_low          <= cfg_data;
        REG_SHORT_HIGH:   cfg.short_high         <= cfg_data;
        REG_LONG_LOW:     cfg.long_low           <= cfg_data;
        REG_LONG_HIGH:    cfg.long_high          <= cfg_data;
        REG_MERGED_LIMIT: cfg.merged_start_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- input stage ----------------
  // the held half moves on unless it is a last half and the result is stuck
  assign adv        = in_valid_q && (!in_q.last || !result_valid || result_ready);
  assign item_ready = !in_valid_q || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (item_ready) begin
      in_valid_q <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      in_q <= item;
    end
  end

  // ---------------- decode ----------------
  // ordinary half applied to the running state
  bfd_half_step u_half (
    .cfg      (cfg),
    .cur      (st),
    .duration (in_q.duration),
    .level    (in_q.level),
    .nxt      (half_next),
    .is_stop  (half_stop)
  );

  // injected level-high half for a start bit merged with the first data bit
  bfd_half_step u_merged (
    .cfg      (cfg),
    .cur      (DEC_CLEAR),
    .duration (MERGED_FILL_US),
    .level    (1'b1),
    .nxt      (merged_next),
    .is_stop  (merged_stop)
  );

  always_comb begin
    st_next               = st;
    stopped_next          = stopped;
    just_after_first_next = 1'b0;
    if (in_q.first) begin
      // first half clears everything, only its length matters
      st_next               = (in_q.duration > cfg.merged_start_limit) ? merged_next
                                                                        : DEC_CLEAR;
      stopped_next          = 1'b0;
      just_after_first_next = 1'b1;
    end else if (!stopped) begin
      st_next = half_next;
      // a stop straight after the first half does not freeze
      if (half_stop && !just_after_first) begin
        stopped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st               <= DEC_CLEAR;
      stopped          <= 1'b0;
      just_after_first <= 1'b0;
    end else if (adv) begin
      st               <= st_next;
      stopped          <= stopped_next;
      just_after_first <= just_after_first_next;
    end
  end

  // ---------------- result register ----------------
  assign frame_wide = WIDE_WIDTH'(st_next.frame);
  assign count_next = st_next.half_index[INDEX_W-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv && in_q.last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_q.last) begin
      result.frame_bits     <= frame_wide[RESULT_WIDTH-1:0];
      result.bit_count      <= count_next;
      result.response_byte  <= frame_wide[7:0];
      result.response_valid <= (count_next == RESPONSE_BITS);
    end
  end

  // ---------------- checks ----------------
  // back-pressure only ever comes from a last half behind a stuck result
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (in_valid_q && in_q.last && result_valid && !result_ready))
    else $error("input stalled without a pending result");

  // a first half always releases a frozen decoder
  a_first_unfreezes: assert property (@(posedge clk) disable iff (rst)
    (adv && in_q.first) |=> (!stopped && just_after_first))
    else $error("decoder still frozen after first half");

  // after a first half at most the injected half has been decoded
  a_first_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && in_q.first) |=> (st.frame == '0 && st.half_index <= INDEX_W'(2)))
    else $error("first half left stale frame state");

  // a new result only follows a last half leaving the input register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(adv && in_q.last))
    else $error("result raised without a last half");

  // the injected half has a nonzero length and is never taken as a stop
  a_merged_not_stop: assert property (@(posedge clk) disable iff (rst)
    !merged_stop)
    else $error("injected half seen as a stop");

endmodule

// File: src/bfd_half_step.sv
// ----------------------------------------------------------------------------
// bfd_half_step: one half period applied to the decoder state
// Window classification, half-bit index advance and edge-to-bit shifting.
// ----------------------------------------------------------------------------
module bfd_half_step (
  input  bfd_pkg::cfg_t                    cfg,
  input  bfd_pkg::dec_state_t              cur,
  input  logic [bfd_pkg::DUR_W-1:0]        duration,
  input  logic                             level,
  output bfd_pkg::dec_state_t              nxt,
  output logic                             is_stop
);
  import bfd_pkg::*;

  logic               in_short;
  logic               in_long;
  logic [INDEX_W-1:0] idx_one;
  logic               push_edge;
  logic               push_stop;

  assign is_stop  = (duration == '0);
  assign in_short = (duration > cfg.short_low) && (duration < cfg.short_high);
  assign in_long  = (duration > cfg.long_low) && (duration < cfg.long_high);

  assign idx_one   = cur.half_index + INDEX_W'(1);
  // edge on an even index marks a bit centre
  assign push_edge = !idx_one[0] && (level != cur.previous_level);
  // stop after a low half on an odd index closes a trailing one
  assign push_stop = !cur.previous_level && cur.half_index[0];

  always_comb begin
    nxt = cur;
    if (is_stop) begin
      if (push_stop) begin
        nxt.half_index = idx_one;
        nxt.frame      = {cur.frame[FRAME_WIDTH-2:0], 1'b1};
      end
    end else if (in_short || in_long) begin
      nxt.half_index     = in_short ? idx_one : (idx_one + INDEX_W'(1));
      nxt.previous_level = level;
      if (push_edge) begin
        nxt.frame = {cur.frame[FRAME_WIDTH-2:0], level};
      end
    end
  end

endmodule

// File: tb/biphase_frame_decoder_tb.sv
// ----------------------------------------------------------------------------
// biphase_frame_decoder_tb: self-checking bench for the biphase frame decoder
// A fixed table of halves runs first: reset state, window edges, stops,
// the frozen state and merged starts. Random captures follow under several
// window settings. Every result beat is checked field by field, against a fixed
// table result or a half-by-half tracker of the decoder kept inside the bench.
// ----------------------------------------------------------------------------
module biphase_frame_decoder_tb;
  import bfd_pkg::*;

  localparam int SETTLE_CYCLES      = 8;
  localparam int WATCHDOG_LIMIT     = 5000;
  localparam int LONG_HOLD          = 400;
  localparam int HOLD_AFTER_RESULTS = 15;
  localparam int DIRECTED_ROWS      = 24;
  // index past the end of the register list, writes must be dropped
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 3'd7;
  localparam result_t ZERO_FRAME = '0;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [DUR_W-1:0]       cfg_data     = '0;
  logic                   item_valid   = 1'b0;
  logic                   item_ready;
  item_t                  item         = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;

  biphase_frame_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // decoder tracker: window settings and decoder state as the bench sees them
  // --------------------------------------------------------------------------
  cfg_t       win;
  dec_state_t trk;
  bit         trk_frozen;
  bit         trk_after_first;

  // decoded frames still owed by the block, oldest first
  result_t    awaited_frames[$];

  int mismatches     = 0;
  int frames_checked = 0;
  int halves_sent    = 0;
  int cfg_writes     = 0;
  int settings_used  = 0;
  int quiet_cycles   = 0;
  int burst_left     = 0;

  function automatic void clear_track();
    trk             = DEC_CLEAR;
    trk_frozen      = 1'b0;
    trk_after_first = 1'b0;
  endfunction

  // one half through the window tests; returns 1 when the half is a stop
  function automatic bit apply_half(logic [DUR_W-1:0] dur, logic lvl);
    bit in_short;
    bit in_long;
    in_short = (dur > win.short_low) && (dur < win.short_high);
    in_long  = (dur > win.long_low) && (dur < win.long_high);
    if (dur == '0) begin
      // a stop closes a pending low half with a final 1
      if (!trk.previous_level && trk.half_index[0]) begin
        trk.half_index = trk.half_index + INDEX_W'(1);
        trk.frame      = {trk.frame[FRAME_WIDTH-2:0], 1'b1};
      end
      return 1'b1;
    end
    if (in_short || in_long) begin
      trk.half_index = trk.half_index + INDEX_W'(1);
      // level change landing on a bit boundary carries the new level in
      if (!trk.half_index[0] && (lvl != trk.previous_level)) begin
        trk.frame = {trk.frame[FRAME_WIDTH-2:0], lvl};
      end
      // short window wins where the two overlap
      if (!in_short) begin
        trk.half_index = trk.half_index + INDEX_W'(1);
      end
      trk.previous_level = lvl;
    end
    return 1'b0;
  endfunction

  // advance the tracker by one half; returns 1 when a result beat is owed
  function automatic bit track_half(item_t it, output result_t res);
    logic [WIDE_WIDTH-1:0] wide;
    if (it.first) begin
      clear_track();
      // start bit merged with the first data bit: stand-in level-1 half
      if (it.duration > win.merged_start_limit) begin
        void'(apply_half(MERGED_FILL_US, 1'b1));
      end
      trk_after_first = 1'b1;
    end else begin
      if (!trk_frozen) begin
        if (apply_half(it.duration, it.level) && !trk_after_first) begin
          trk_frozen = 1'b1;
        end
      end
      trk_after_first = 1'b0;
    end
    wide               = WIDE_WIDTH'(trk.frame);
    res.frame_bits     = wide[RESULT_WIDTH-1:0];
    res.bit_count      = trk.half_index[INDEX_W-1:1];
    res.response_byte  = res.frame_bits[7:0];
    res.response_valid = (res.bit_count == RESPONSE_BITS);
    return it.last;
  endfunction

  task automatic note_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // directed table: halves under the reset windows (333/500, 667/1000, 650)
  // --------------------------------------------------------------------------
  typedef struct {
    item_t   half;
    bit      fixed;
    result_t want;
  } step_row_t;

  step_row_t directed_rows [DIRECTED_ROWS] = '{
    // stop straight after reset: idle high, nothing appended, decoder freezes
    '{'{16'd0,     1'b1, 1'b0, 1'b1}, 1'b1, ZERO_FRAME},
    // frozen decoder still answers a last half
    '{'{16'd400,   1'b1, 1'b0, 1'b1}, 1'b1, ZERO_FRAME},
    // first and last together, plain start
    '{'{16'd400,   1'b0, 1'b1, 1'b1}, 1'b1, ZERO_FRAME},
    // first and last together, merged start: one half only, count still 0
    '{'{16'd65535, 1'b0, 1'b1, 1'b1}, 1'b1, ZERO_FRAME},
    // merged start opening a capture
    '{'{16'd65535, 1'b1, 1'b1, 1'b0}, 1'b0, ZERO_FRAME},
    '{'{16'd400,   1'b0, 1'b0, 1'b0}, 1'b0, ZERO_FRAME},
    '{'{16'd800,   1'b1, 1'b0, 1'b0}, 1'b0, ZERO_FRAME},
    '{'{16'd400,   1'b0, 1'b0, 1'b0}, 1'b0, ZERO_FRAME},
    '{'{16'd400,   1'b1, 1'b0, 1'b0}, 1'b0, ZERO_FRAME},
    // window bounds are exclusive, the gap between windows is ignored
    '{'{16'd1000,  1'b0, 1'b0, 1'b0}, 1'b0, ZERO_FRAME},
    '{'{16'd333,   1'b0, 1'b0, 1'b0}, 1'b0, ZERO_FRAME},
    '{'{16'd500,   1'b0, 1'b0, 1'b0}, 1'b0, ZERO_FRAME},
    '{'{16'd667,   1'b0, 1'b0, 1'b0}, 1'b0, ZERO_FRAME},
    '{'{16'd650,   1'b0, 1'b0, 1'b0}, 1'b0, ZERO_FRAME},
    '{'{16'd400,   1'b0, 1'b0, 1'b0}, 1'b0, ZERO_FRAME},
    // stop after an odd low half appends a 1, then freezes
    '{'{16'd0,     1'b1, 1'b0, 1'b0}, 1'b0, ZERO_FRAME},
    '{'{16'd400,   1'b1, 1'b0, 1'b0}, 1'b0, ZERO_FRAME},
    '{'{16'd0,     1'b0, 1'b0, 1'b1}, 1'b0, ZERO_FRAME},
    // stop right after a first half does not freeze
    '{'{16'd300,   1'b1, 1'b1, 1'b0}, 1'b0, ZERO_FRAME},
    '{'{16'd0,     1'b0, 1'b0, 1'b0}, 1'b0, ZERO_FRAME},
    '{'{16'd401,   1'b0, 1'b0, 1'b0}, 1'b0, ZERO_FRAME},
    '{'{16'd999,   1'b1, 1'b0, 1'b0}, 1'b0, ZERO_FRAME},
    '{'{16'd334,   1'b0, 1'b0, 1'b1}, 1'b0, ZERO_FRAME},
    // first half exactly at the merge limit is not merged
    '{'{16'd650,   1'b1, 1'b1, 1'b1}, 1'b1, ZERO_FRAME}
  };

  // --------------------------------------------------------------------------
  // sender: bursts of random length with random gaps between them
  // --------------------------------------------------------------------------
  task automatic send_item(item_t it, bit fixed, result_t fixed_res);
    int      gap;
    result_t res;
    if (burst_left == 0) begin
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    // beat taken: move the tracker on and record what the block owes
    if (track_half(it, res)) begin
      awaited_frames.push_back(fixed ? fixed_res : res);
    end
    halves_sent++;
  endtask

  // sender pauses until every owed result is in and the pipe has emptied
  task automatic drain();
    item_valid <= 1'b0;
    while (awaited_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [DUR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SHORT_LOW:    win.short_low          = data;
      REG_SHORT_HIGH:   win.short_high         = data;
      REG_LONG_LOW:     win.long_low           = data;
      REG_LONG_HIGH:    win.long_high          = data;
      REG_MERGED_LIMIT: win.merged_start_limit = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic load_windows(cfg_t c);
    write_reg(REG_SHORT_LOW,    c.short_low);
    write_reg(REG_SHORT_HIGH,   c.short_high);
    write_reg(REG_LONG_LOW,     c.long_low);
    write_reg(REG_LONG_HIGH,    c.long_high);
    write_reg(REG_MERGED_LIMIT, c.merged_start_limit);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // a duration strictly inside (lo, hi), any nonzero one when the window is empty
  function automatic logic [DUR_W-1:0] pick_between(logic [DUR_W-1:0] lo,
                                                    logic [DUR_W-1:0] hi);
    if (int'(hi) > int'(lo) + 1) begin
      return DUR_W'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    end
    return DUR_W'($urandom_range(1, 65535));
  endfunction

  function automatic logic [DUR_W-1:0] pick_merged();
    int lim;
    lim = int'(win.merged_start_limit);
    if (lim >= 65535) begin
      return '1;
    end
    return DUR_W'($urandom_range(lim + 1, (lim + 500 > 65535) ? 65535 : lim + 500));
  endfunction

  // one capture: start bit and data bits as alternating levels, with an
  // ending of random kind (stop, plain last, stray halves, cut short, none)
  task automatic send_frame();
    int    nbits;
    int    k;
    int    end_kind;
    bit    b;
    logic  lv[$];
    item_t halves[$];
    item_t it;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: nbits = $urandom_range(6, 9);
      4, 5:       nbits = 16;
      6:          nbits = 24;
      7:          nbits = $urandom_range(33, 40);
      default:    nbits = $urandom_range(0, 32);
    endcase
    lv.push_back(1'b0);
    lv.push_back(1'b1);
    for (k = 0; k < nbits; k++) begin
      b = $urandom_range(0, 1);
      lv.push_back(!b);
      lv.push_back(b);
    end
    // equal neighbouring levels merge into one long half
    k = 0;
    while (k < lv.size()) begin
      it       = '0;
      it.level = lv[k];
      if ((k + 1 < lv.size()) && (lv[k + 1] == lv[k])) begin
        it.duration = pick_between(win.long_low, win.long_high);
        k += 2;
      end else begin
        it.duration = pick_between(win.short_low, win.short_high);
        k += 1;
      end
      if (halves.size() == 0) begin
        it.first = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          it.duration = pick_merged();
          k += 1;
        end
      end
      // glitched measurement
      if ($urandom_range(0, 24) == 0) begin
        it.duration = DUR_W'($urandom);
      end
      halves.push_back(it);
    end
    end_kind = $urandom_range(0, 9);
    if (end_kind == 9) begin
      while ((halves.size() > 1) && ($urandom_range(0, 3) != 0)) begin
        it = halves.pop_back();
      end
    end
    if (end_kind <= 4 || end_kind == 7) begin
      it          = '0;
      it.level    = $urandom_range(0, 1);
      halves.push_back(it);
    end
    if (end_kind == 7) begin
      // halves after a stop must be ignored
      repeat ($urandom_range(1, 3)) begin
        it          = '0;
        it.level    = $urandom_range(0, 1);
        it.duration = pick_between(win.short_low, win.short_high);
        halves.push_back(it);
      end
    end
    if (end_kind != 8) begin
      halves[halves.size() - 1].last = 1'b1;
    end
    foreach (halves[i]) begin
      send_item(halves[i], 1'b0, ZERO_FRAME);
    end
  endtask

  task automatic send_noise();
    item_t it;
    it.duration = ($urandom_range(0, 3) == 0) ? '0 : DUR_W'($urandom);
    it.level    = $urandom_range(0, 1);
    it.first    = ($urandom_range(0, 7) == 0);
    it.last     = ($urandom_range(0, 5) == 0);
    send_item(it, 1'b0, ZERO_FRAME);
  endtask

  task automatic run_phase(int budget);
    int start;
    start = halves_sent;
    while (halves_sent - start < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        send_frame();
      end
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // receiver: its own stall pattern, plus one long hold-off so that held
  // results back up into the input side
  // --------------------------------------------------------------------------
  int rx_cycle = 0;
  int rx_beats = 0;
  int rx_hold  = 0;
  bit rx_hold_done = 1'b0;

  always @(posedge clk) begin
    if (result_valid && result_ready) begin
      rx_beats++;
      if (!rx_hold_done && (rx_beats == HOLD_AFTER_RESULTS)) begin
        rx_hold      = LONG_HOLD;
        rx_hold_done = 1'b1;
      end
    end
    if (rx_hold > 0) begin
      rx_hold--;
      result_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 97) % 4)
        0:       result_ready <= 1'b1;
        1:       result_ready <= ((rx_cycle % 3) == 0);
        2:       result_ready <= $urandom_range(0, 1);
        default: result_ready <= ((rx_cycle % 8) >= 5);
      endcase
    end
    rx_cycle++;
  end

  // --------------------------------------------------------------------------
  // result checking and activity count for the watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if ((item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (!rst && result_valid && result_ready) begin
      if (awaited_frames.size() == 0) begin
        note_mismatch($sformatf("result beat with nothing owed, frame %h", result.frame_bits));
      end else begin
        want = awaited_frames.pop_front();
        if (result.frame_bits !== want.frame_bits) begin
          note_mismatch($sformatf("frame_bits %h, wanted %h",
                                  result.frame_bits, want.frame_bits));
        end
        if (result.bit_count !== want.bit_count) begin
          note_mismatch($sformatf("bit_count %0d, wanted %0d",
                                  result.bit_count, want.bit_count));
        end
        if (result.response_byte !== want.response_byte) begin
          note_mismatch($sformatf("response_byte %h, wanted %h",
                                  result.response_byte, want.response_byte));
        end
        if (result.response_valid !== want.response_valid) begin
          note_mismatch($sformatf("response_valid %b, wanted %b",
                                  result.response_valid, want.response_valid));
        end
      end
      frames_checked++;
    end
  end

  // no beat on any channel for too long: give up
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t c;
    int   k;
    win = CFG_RESET;
    clear_track();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table, reset windows
    for (k = 0; k < DIRECTED_ROWS; k++) begin
      send_item(directed_rows[k].half, directed_rows[k].fixed, directed_rows[k].want);
    end
    drain();

    // defaults written back explicitly
    load_windows(CFG_RESET);
    run_phase(200);

    // tight windows
    c = '{short_low: 16'd380, short_high: 16'd460, long_low: 16'd790,
          long_high: 16'd880, merged_start_limit: 16'd600};
    load_windows(c);
    run_phase(200);

    // widest windows, every nonzero first half merged
    c = '{short_low: 16'd0, short_high: 16'hFFFF, long_low: 16'd0,
          long_high: 16'hFFFF, merged_start_limit: 16'd0};
    load_windows(c);
    run_phase(180);

    // overlapping windows, merging never happens
    c = '{short_low: 16'd100, short_high: 16'd900, long_low: 16'd300,
          long_high: 16'd1200, merged_start_limit: 16'hFFFF};
    load_windows(c);
    run_phase(200);

    // everything zero: both windows empty
    load_windows('0);
    run_phase(100);

    // random windows; a stray write past the register list goes first
    write_reg(CFG_INDEX_SPARE, DUR_W'($urandom));
    c.short_low          = DUR_W'($urandom_range(0, 1500));
    c.short_high         = c.short_low + DUR_W'($urandom_range(0, 800));
    c.long_low           = c.short_high + DUR_W'($urandom_range(0, 400)) - DUR_W'(100);
    c.long_high          = c.long_low + DUR_W'($urandom_range(0, 1500));
    c.merged_start_limit = DUR_W'($urandom_range(0, 3000));
    load_windows(c);
    run_phase(200);

    // everything at the top: nothing decodes
    load_windows('1);
    run_phase(100);

    if (awaited_frames.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", awaited_frames.size()));
    end
    $display("run covered %0d halves under %0d window settings (%0d register writes)",
             halves_sent, settings_used, cfg_writes);
    $display("%0d decoded frames compared, %0d field errors", frames_checked, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
